@@ design/dcfl_pkg.sv @@
package dcfl_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int TAP_COUNT    = 51;
  localparam int COEF_BITS    = 16;
  localparam int FRAC_BITS    = 15;
  localparam int TAP_IDX_BITS = $clog2(TAP_COUNT);
  localparam int PROD_BITS    = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_BITS     = PROD_BITS + $clog2(TAP_COUNT) + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic [TAP_IDX_BITS-1:0]       tap_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_t;

  function automatic coef_t tap_coef(input tap_idx_t k);
    coef_t c;
    case (k)
      1, 49:   c = 16'sd5;
      2, 48:   c = 16'sd13;
      3, 47:   c = 16'sd23;
      4, 46:   c = 16'sd39;
      5, 45:   c = 16'sd61;
      6, 44:   c = 16'sd91;
      7, 43:   c = 16'sd131;
      8, 42:   c = 16'sd180;
      9, 41:   c = 16'sd240;
      10, 40:  c = 16'sd312;
      11, 39:  c = 16'sd393;
      12, 38:  c = 16'sd485;
      13, 37:  c = 16'sd585;
      14, 36:  c = 16'sd691;
      15, 35:  c = 16'sd801;
      16, 34:  c = 16'sd914;
      17, 33:  c = 16'sd1025;
      18, 32:  c = 16'sd1133;
      19, 31:  c = 16'sd1234;
      20, 30:  c = 16'sd1325;
      21, 29:  c = 16'sd1403;
      22, 28:  c = 16'sd1467;
      23, 27:  c = 16'sd1514;
      24, 26:  c = 16'sd1543;
      25:      c = 16'sd1552;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ design/dcfl_in_if.sv @@
interface dcfl_in_if import dcfl_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t red_sample;
  sample_t ir_sample;

  modport source (output valid, output red_sample, output ir_sample, input ready);
  modport sink   (input valid, input red_sample, input ir_sample, output ready);
endinterface

@@ design/dcfl_out_if.sv @@
interface dcfl_out_if import dcfl_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t red_filtered;
  sample_t ir_filtered;

  modport source (output valid, output red_filtered, output ir_filtered, input ready);
  modport sink   (input valid, input red_filtered, input ir_filtered, output ready);
endinterface

@@ design/dual_channel_fir_lowpass_unit.sv @@
// Dual-channel 51-tap lowpass FIR. Each request carries one red and one infrared
// sample; both channels pass through the same fixed Q1.15 symmetric lowpass, and
// each result is rounded (halves toward plus infinity) and saturated to 16 bits.
// Each channel keeps its 51 newest samples in a circular shift line that is
// cleared by reset. One multiply-accumulate lane per channel walks the taps, one
// tap per cycle; a request then passes the product drain state and the done
// state, which rounds and loads the output register once it is empty or being
// read, then returns to idle. The input is ready only in the idle state; a
// finished result waits in the output register while the next request is taken.
module dual_channel_fir_lowpass_unit import dcfl_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  dcfl_in_if.sink       in_chan,
  dcfl_out_if.source    out_chan
);

  localparam int Y_BITS = ACC_BITS - FRAC_BITS;
  localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [Y_BITS-1:0] Y_MAX = Y_BITS'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [Y_BITS-1:0] Y_MIN = -Y_MAX - Y_BITS'(1);

  state_t   state_r, state_nxt;
  tap_idx_t tap_r, tap_nxt;
  sample_t  red_line_r [TAP_COUNT];
  sample_t  red_line_nxt [TAP_COUNT];
  sample_t  ir_line_r [TAP_COUNT];
  sample_t  ir_line_nxt [TAP_COUNT];
  prod_t    red_prod_r, red_prod_nxt;
  prod_t    ir_prod_r, ir_prod_nxt;
  logic     prod_vld_r, prod_vld_nxt;
  acc_t     red_acc_r, red_acc_nxt;
  acc_t     ir_acc_r, ir_acc_nxt;
  logic     out_valid_r, out_valid_nxt;
  sample_t  red_out_r, red_out_nxt;
  sample_t  ir_out_r, ir_out_nxt;

  logic     accept;
  logic     load_out;
  coef_t    coef;
  acc_t     red_rnd, ir_rnd;
  logic signed [Y_BITS-1:0] red_y, ir_y;
  sample_t  red_sat, ir_sat;

  assign accept   = in_chan.valid && (state_r == ST_IDLE);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);
  assign coef     = tap_coef(tap_r);

  assign red_rnd = red_acc_r + ROUND_HALF;
  assign ir_rnd  = ir_acc_r + ROUND_HALF;
  assign red_y   = red_rnd[ACC_BITS-1:FRAC_BITS];
  assign ir_y    = ir_rnd[ACC_BITS-1:FRAC_BITS];

  always_comb begin
    if (red_y > Y_MAX) begin
      red_sat = Y_MAX[SAMPLE_BITS-1:0];
    end else if (red_y < Y_MIN) begin
      red_sat = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      red_sat = red_y[SAMPLE_BITS-1:0];
    end
    if (ir_y > Y_MAX) begin
      ir_sat = Y_MAX[SAMPLE_BITS-1:0];
    end else if (ir_y < Y_MIN) begin
      ir_sat = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      ir_sat = ir_y[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    red_line_nxt  = red_line_r;
    ir_line_nxt   = ir_line_r;
    red_prod_nxt  = prod_t'(coef) * prod_t'(red_line_r[0]);
    ir_prod_nxt   = prod_t'(coef) * prod_t'(ir_line_r[0]);
    prod_vld_nxt  = (state_r == ST_MAC);
    red_acc_nxt   = red_acc_r;
    ir_acc_nxt    = ir_acc_r;
    out_valid_nxt = out_valid_r;
    red_out_nxt   = red_out_r;
    ir_out_nxt    = ir_out_r;

    if (prod_vld_r) begin
      red_acc_nxt = red_acc_r + ACC_BITS'(red_prod_r);
      ir_acc_nxt  = ir_acc_r + ACC_BITS'(ir_prod_r);
    end

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // shift in the new sample, drop the oldest
          for (int i = 1; i < TAP_COUNT; i++) begin
            red_line_nxt[i] = red_line_r[i-1];
            ir_line_nxt[i]  = ir_line_r[i-1];
          end
          red_line_nxt[0] = in_chan.red_sample;
          ir_line_nxt[0]  = in_chan.ir_sample;
          tap_nxt         = '0;
          red_acc_nxt     = '0;
          ir_acc_nxt      = '0;
          state_nxt       = ST_MAC;
        end
      end
      ST_MAC: begin
        // rotate so the next tap sits at the head
        for (int i = 0; i < TAP_COUNT - 1; i++) begin
          red_line_nxt[i] = red_line_r[i+1];
          ir_line_nxt[i]  = ir_line_r[i+1];
        end
        red_line_nxt[TAP_COUNT-1] = red_line_r[0];
        ir_line_nxt[TAP_COUNT-1]  = ir_line_r[0];
        tap_nxt = tap_r + tap_idx_t'(1);
        if (tap_r == tap_idx_t'(TAP_COUNT - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          red_out_nxt   = red_sat;
          ir_out_nxt    = ir_sat;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_r       <= '0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TAP_COUNT; i++) begin
        red_line_r[i] <= '0;
        ir_line_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      prod_vld_r  <= prod_vld_nxt;
      out_valid_r <= out_valid_nxt;
      red_line_r  <= red_line_nxt;
      ir_line_r   <= ir_line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_prod_r <= red_prod_nxt;
    ir_prod_r  <= ir_prod_nxt;
    red_acc_r  <= red_acc_nxt;
    ir_acc_r   <= ir_acc_nxt;
    red_out_r  <= red_out_nxt;
    ir_out_r   <= ir_out_nxt;
  end

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.red_filtered = red_out_r;
  assign out_chan.ir_filtered  = ir_out_r;

endmodule
